@@ rtl/core/hnm_pkg.sv @@
`timescale 1ns / 1ps

package hnm_pkg;

    localparam int MaxWidth = 4096;
    localparam int AddrW    = $clog2(MaxWidth);
    localparam int CoordW   = 12;
    localparam int QDepth   = 4;
    localparam int QPtrW    = $clog2(QDepth);

    localparam logic [1:0] CfgWidth    = 2'd0;
    localparam logic [1:0] CfgHeight   = 2'd1;
    localparam logic [1:0] CfgStrength = 2'd2;

    typedef struct packed {
        logic [CoordW-1:0] col;
        logic [CoordW-1:0] row;
        logic [7:0]        centre;
        logic [7:0]        right;
        logic [7:0]        below;
        logic              last;
    } t_job;

    typedef struct packed {
        logic [CoordW-1:0] wm1;
        logic [CoordW-1:0] hm1;
    } t_geom;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_EMIT
    } t_fstate;

    typedef enum logic [3:0] {
        B_IDLE,
        B_XY,
        B_SQX,
        B_SQY,
        B_DIV,
        B_SQRT,
        B_Z,
        B_PX,
        B_PY,
        B_OUT
    } t_bstate;

endpackage

@@ rtl/core/hnm_queue.sv @@
`timescale 1ns / 1ps

module hnm_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hnm_pkg::t_job       i_din,
    input  logic                i_pop,
    output hnm_pkg::t_job       o_dout,
    output hnm_pkg::t_qstat     o_stat
);

    hnm_pkg::t_job                r_ent [hnm_pkg::QDepth];
    logic [hnm_pkg::QPtrW-1:0]    r_wp;
    logic [hnm_pkg::QPtrW-1:0]    r_rp;
    logic [hnm_pkg::QPtrW:0]      r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_din;
        end
    end

    assign o_dout       = r_ent[r_rp];
    assign o_stat.full  = (r_cnt == (hnm_pkg::QPtrW+1)'(hnm_pkg::QDepth));
    assign o_stat.empty = (r_cnt == '0);

endmodule

@@ rtl/core/hnm_front.sv @@
`timescale 1ns / 1ps

module hnm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_height_sample,
    input  hnm_pkg::t_geom      i_geom,
    input  logic                i_restart,
    input  logic                i_q_full,
    output logic                o_push,
    output hnm_pkg::t_job       o_job
);

    hnm_pkg::t_fstate              r_state;
    hnm_pkg::t_fstate              n_state;
    logic [7:0]                    r_mem [hnm_pkg::MaxWidth];
    logic [7:0]                    r_rd0;
    logic [7:0]                    r_rd1;
    logic [hnm_pkg::CoordW-1:0]    r_col;
    logic [hnm_pkg::CoordW-1:0]    r_row;
    logic [7:0]                    r_prior;
    logic [7:0]                    r_prv;
    logic [7:0]                    r_cur;
    logic [hnm_pkg::CoordW-1:0]    r_c;
    logic [hnm_pkg::CoordW-1:0]    r_r;
    logic                          r_lc;
    logic                          r_lr;
    logic [2:0]                    r_mask;
    logic [2:0]                    n_mask;

    logic [hnm_pkg::CoordW-1:0]    c;
    logic [hnm_pkg::CoordW-1:0]    r;
    logic                          lc;
    logic                          lr;
    logic                          accept;
    logic [hnm_pkg::AddrW-1:0]     a0;
    logic [hnm_pkg::AddrW-1:0]     a1;

    assign c      = (r_col > i_geom.wm1) ? i_geom.wm1 : r_col;
    assign r      = (r_row > i_geom.hm1) ? i_geom.hm1 : r_row;
    assign lc     = (c == i_geom.wm1);
    assign lr     = (r == i_geom.hm1);
    assign accept = i_valid && (r_state == hnm_pkg::F_IDLE);
    assign o_stall = (r_state != hnm_pkg::F_IDLE);
    assign a0     = c[hnm_pkg::AddrW-1:0];
    assign a1     = a0 + 1'b1;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd0 <= r_mem[a0];
            r_rd1 <= r_mem[a1];
        end
        if (r_state == hnm_pkg::F_READ) begin
            r_mem[r_c[hnm_pkg::AddrW-1:0]] <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur <= i_height_sample;
            r_prv <= r_prior;
            r_c   <= c;
            r_r   <= r;
            r_lc  <= lc;
            r_lr  <= lr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hnm_pkg::F_IDLE;
            r_mask  <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_prior <= '0;
        end else begin
            r_state <= n_state;
            r_mask  <= n_mask;
            if (i_restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (r_state == hnm_pkg::F_READ) begin
                r_prior <= r_cur;
                if (r_lc) begin
                    r_col <= '0;
                    r_row <= r_lr ? '0 : r_r + 1'b1;
                end else begin
                    r_col <= r_c + 1'b1;
                    r_row <= r_r;
                end
            end
        end
    end

    always_comb begin
        logic [2:0] sel;
        logic [2:0] rest;
        sel     = r_mask & (~r_mask + 3'd1);
        rest    = r_mask & ~sel;
        n_state = r_state;
        n_mask  = r_mask;
        o_push  = 1'b0;
        o_job   = '0;
        if (sel[0]) begin
            o_job.col    = r_c;
            o_job.row    = r_r - 1'b1;
            o_job.centre = r_rd0;
            o_job.right  = r_lc ? r_rd0 : r_rd1;
            o_job.below  = r_cur;
        end else if (sel[1]) begin
            o_job.col    = r_c - 1'b1;
            o_job.row    = r_r;
            o_job.centre = r_prv;
            o_job.right  = r_cur;
            o_job.below  = r_prv;
        end else begin
            o_job.col    = r_c;
            o_job.row    = r_r;
            o_job.centre = r_cur;
            o_job.right  = r_cur;
            o_job.below  = r_cur;
        end
        o_job.last = (rest == '0);
        case (r_state)
            hnm_pkg::F_IDLE: begin
                if (accept) begin
                    n_state = hnm_pkg::F_READ;
                    n_mask  = {lr && lc, lr && (c != '0), r != '0};
                end
            end
            hnm_pkg::F_READ: begin
                n_state = (r_mask != '0) ? hnm_pkg::F_EMIT : hnm_pkg::F_IDLE;
            end
            hnm_pkg::F_EMIT: begin
                if (!i_q_full) begin
                    o_push = 1'b1;
                    n_mask = rest;
                    if (rest == '0) begin
                        n_state = hnm_pkg::F_IDLE;
                    end
                end
            end
            default: begin
                n_state = hnm_pkg::F_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/hnm_back.sv @@
`timescale 1ns / 1ps

module hnm_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic signed [15:0]          i_strength,
    input  hnm_pkg::t_job               i_job,
    input  logic                        i_q_empty,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [hnm_pkg::CoordW-1:0]  o_out_col,
    output logic [hnm_pkg::CoordW-1:0]  o_out_row,
    output logic [7:0]                  o_blue_z,
    output logic [7:0]                  o_green_y,
    output logic [7:0]                  o_red_x,
    output logic                        o_run_end
);

    hnm_pkg::t_bstate      r_state;
    hnm_pkg::t_bstate      n_state;
    hnm_pkg::t_job         r_job;
    logic signed [24:0]    r_x;
    logic signed [24:0]    r_y;
    logic [47:0]           r_sq;
    logic [48:0]           r_rem;
    logic [33:0]           r_q;
    logic [5:0]            r_cnt;
    logic [19:0]           r_srem;
    logic [16:0]           r_root;
    logic [23:0]           r_z;
    logic [7:0]            r_blue;
    logic [7:0]            r_green;
    logic [7:0]            r_red;

    logic signed [8:0]     dx;
    logic signed [8:0]     dy;
    logic signed [49:0]    sqx;
    logic signed [49:0]    sqy;
    logic [48:0]           dtrial;
    logic                  dge;
    logic [19:0]           snext;
    logic [19:0]           strial;
    logic                  sge;
    logic [24:0]           magx;
    logic [24:0]           magy;
    logic [47:0]           px;
    logic [47:0]           py;

    assign dx     = $signed({1'b0, r_job.right}) - $signed({1'b0, r_job.centre});
    assign dy     = $signed({1'b0, r_job.below}) - $signed({1'b0, r_job.centre});
    assign sqx    = r_x * r_x;
    assign sqy    = r_y * r_y;
    assign dtrial = {r_rem[47:0], (r_cnt == 6'd48)};
    assign dge    = (dtrial >= {1'b0, r_sq});
    assign snext  = {r_srem[17:0], r_q[33:32]};
    assign strial = {1'b0, r_root, 2'b01};
    assign sge    = (snext >= strial);
    assign magx   = r_x[24] ? -r_x : r_x;
    assign magy   = r_y[24] ? -r_y : r_y;
    assign px     = magx[23:0] * r_z;
    assign py     = magy[23:0] * r_z;

    always_ff @(posedge i_clk) begin
        case (r_state)
            hnm_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    r_job <= i_job;
                end
            end
            hnm_pkg::B_XY: begin
                r_x <= 25'(i_strength * dx);
                r_y <= 25'(i_strength * dy);
            end
            hnm_pkg::B_SQX: begin
                r_sq <= sqx[47:0];
            end
            hnm_pkg::B_SQY: begin
                r_sq  <= r_sq + sqy[47:0] + 48'd65536;
                r_rem <= '0;
                r_q   <= '0;
                r_cnt <= 6'd48;
            end
            hnm_pkg::B_DIV: begin
                r_rem <= dge ? dtrial - {1'b0, r_sq} : dtrial;
                r_q   <= {r_q[32:0], dge};
                if (r_cnt == '0) begin
                    r_cnt  <= 6'd16;
                    r_srem <= '0;
                    r_root <= '0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            hnm_pkg::B_SQRT: begin
                r_srem <= sge ? snext - strial : snext;
                r_root <= {r_root[15:0], sge};
                r_q    <= {r_q[31:0], 2'b00};
                r_cnt  <= r_cnt - 1'b1;
            end
            hnm_pkg::B_Z: begin
                r_z <= {r_root, 7'b0} - {7'b0, r_root};
            end
            hnm_pkg::B_PX: begin
                r_blue <= 8'd128 + r_z[23:16];
                r_red  <= 8'd128 - (r_x[24] ? -px[31:24] : px[31:24]);
            end
            hnm_pkg::B_PY: begin
                r_green <= 8'd128 - (r_y[24] ? -py[31:24] : py[31:24]);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hnm_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            hnm_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_state = hnm_pkg::B_XY;
                end
            end
            hnm_pkg::B_XY:  n_state = hnm_pkg::B_SQX;
            hnm_pkg::B_SQX: n_state = hnm_pkg::B_SQY;
            hnm_pkg::B_SQY: n_state = hnm_pkg::B_DIV;
            hnm_pkg::B_DIV: begin
                if (r_cnt == '0) begin
                    n_state = hnm_pkg::B_SQRT;
                end
            end
            hnm_pkg::B_SQRT: begin
                if (r_cnt == '0) begin
                    n_state = hnm_pkg::B_Z;
                end
            end
            hnm_pkg::B_Z:  n_state = hnm_pkg::B_PX;
            hnm_pkg::B_PX: n_state = hnm_pkg::B_PY;
            hnm_pkg::B_PY: n_state = hnm_pkg::B_OUT;
            hnm_pkg::B_OUT: begin
                if (!i_stall) begin
                    n_state = hnm_pkg::B_IDLE;
                end
            end
            default: n_state = hnm_pkg::B_IDLE;
        endcase
    end

    assign o_valid   = (r_state == hnm_pkg::B_OUT);
    assign o_out_col = r_job.col;
    assign o_out_row = r_job.row;
    assign o_run_end = r_job.last;
    assign o_blue_z  = r_blue;
    assign o_green_y = r_green;
    assign o_red_x   = r_red;

endmodule

@@ rtl/core/height_to_normal_map_top.sv @@
`timescale 1ns / 1ps

// channel   valid     stall     payload
// input     i_valid   o_stall   i_height_sample
// output    o_valid   i_stall   o_out_col o_out_row o_blue_z o_green_y o_red_x o_run_end
//
// front: reads the line buffer for each sample, then pushes each result in turn; waits while the 4-entry queue is full
// back works through one result at a time, then waits for the output: 49-step divide, 17-step root
// results trail their samples by one row, up to three per sample on the last row
// synchronous active-low reset clears control state, the line buffer is not cleared
// either side may stall alone; the queue decouples front from back

module height_to_normal_map_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_height_sample,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [hnm_pkg::CoordW-1:0]   o_out_col,
    output logic [hnm_pkg::CoordW-1:0]   o_out_row,
    output logic [7:0]                   o_blue_z,
    output logic [7:0]                   o_green_y,
    output logic [7:0]                   o_red_x,
    output logic                         o_run_end,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [15:0]                  i_cfg_data
);

    logic [12:0]            r_width;
    logic [12:0]            r_height;
    logic signed [15:0]     r_strength;
    hnm_pkg::t_geom         geom;
    logic                   restart;
    logic                   q_push;
    logic                   q_pop;
    hnm_pkg::t_job          q_din;
    hnm_pkg::t_job          q_dout;
    hnm_pkg::t_qstat        q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= 13'd4096;
            r_height   <= 13'd4096;
            r_strength <= 16'sd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hnm_pkg::CfgWidth:    r_width    <= i_cfg_data[12:0];
                hnm_pkg::CfgHeight:   r_height   <= i_cfg_data[12:0];
                hnm_pkg::CfgStrength: r_strength <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign restart  = i_cfg_we && (i_cfg_idx == hnm_pkg::CfgWidth ||
                                   i_cfg_idx == hnm_pkg::CfgHeight ||
                                   i_cfg_idx == hnm_pkg::CfgStrength);
    assign geom.wm1 = (r_width == '0) ? '0 :
                      (r_width > 13'd4096) ? 12'd4095 : 12'(r_width - 1'b1);
    assign geom.hm1 = (r_height == '0) ? '0 :
                      (r_height > 13'd4096) ? 12'd4095 : 12'(r_height - 1'b1);

    hnm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_height_sample (i_height_sample),
        .i_geom          (geom),
        .i_restart       (restart),
        .i_q_full        (q_stat.full),
        .o_push          (q_push),
        .o_job           (q_din)
    );

    hnm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_din   (q_din),
        .i_pop   (q_pop),
        .o_dout  (q_dout),
        .o_stat  (q_stat)
    );

    hnm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_strength (r_strength),
        .i_job      (q_dout),
        .i_q_empty  (q_stat.empty),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_col  (o_out_col),
        .o_out_row  (o_out_row),
        .o_blue_z   (o_blue_z),
        .o_green_y  (o_green_y),
        .o_red_x    (o_red_x),
        .o_run_end  (o_run_end)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("front not busy after taking a sample");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> !o_valid)
        else $error("result shown right after pop");

endmodule

@@ verif/height_to_normal_map_top_tb.sv @@
`timescale 1ns / 1ps

module height_to_normal_map_top_tb;

    localparam int SettleCycles = 400;
    localparam int WatchLimit   = 6000;
    localparam int RandItems    = 350;

    typedef struct packed {
        bit [11:0] col;
        bit [11:0] row;
        bit [7:0]  blue;
        bit [7:0]  green;
        bit [7:0]  red;
        bit        run_end;
    } t_normal_px;

    class normal_scoreboard;
        t_normal_px  pending_px[$];
        bit [7:0]    line_buf[4096];
        bit [11:0]   col_pos;
        bit [11:0]   row_pos;
        bit [7:0]    last_height;
        bit [12:0]   width_reg;
        bit [12:0]   height_reg;
        bit [15:0]   strength_reg;
        int          errors;
        int          inputs_seen;
        int          results_seen;

        function new();
            col_pos = 0;
            row_pos = 0;
            last_height = 0;
            width_reg = 4096;
            height_reg = 4096;
            strength_reg = 256;
            errors = 0;
            inputs_seen = 0;
            results_seen = 0;
        endfunction

        task report(input string what);
            errors++;
            $display("mismatch @%0t: %s", $realtime, what);
        endtask

        function void write_reg(input bit [1:0] idx, input bit [15:0] data);
            case (idx)
                hnm_pkg::CfgWidth: begin
                    width_reg = data[12:0];
                end
                hnm_pkg::CfgHeight: begin
                    height_reg = data[12:0];
                end
                hnm_pkg::CfgStrength: begin
                    strength_reg = data;
                end
                default: begin
                    return;
                end
            endcase
            col_pos = 0;
            row_pos = 0;
        endfunction

        function longint unsigned int_sqrt(input longint unsigned q);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 32;
            while (bitv > q) bitv >>= 2;
            while (bitv != 0) begin
                if (q >= res + bitv) begin
                    q = q - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function bit [31:0] scaled_trunc(input longint v, input longint unsigned z);
            longint unsigned mag;
            longint unsigned p;
            mag = (v < 0) ? longint'(-v) : longint'(v);
            p = (mag * z) >> 24;
            return (v < 0) ? 32'(0 - p) : 32'(p);
        endfunction

        function t_normal_px shade(input bit [11:0] c, input bit [11:0] r,
                                   input bit [7:0] centre, input bit [7:0] right,
                                   input bit [7:0] below);
            t_normal_px px;
            longint s;
            longint xq;
            longint yq;
            longint unsigned sq;
            longint unsigned z;
            s = longint'($signed(strength_reg));
            xq = s * (longint'(right) - longint'(centre));
            yq = s * (longint'(below) - longint'(centre));
            sq = longint'(xq * xq) + longint'(yq * yq) + 65536;
            z = 127 * int_sqrt((64'd1 << 48) / sq);
            px.col = c;
            px.row = r;
            px.blue = 8'(128 + (z >> 16));
            px.green = 8'(32'd128 - scaled_trunc(yq, z));
            px.red = 8'(32'd128 - scaled_trunc(xq, z));
            px.run_end = 0;
            return px;
        endfunction

        function void note_height(input bit [7:0] cur);
            int w;
            int h;
            int c;
            int r;
            int n;
            bit lc;
            bit lr;
            w = width_reg;
            h = height_reg;
            n = 0;
            if (w == 0) w = 1;
            if (w > 4096) w = 4096;
            if (h == 0) h = 1;
            if (h > 4096) h = 4096;
            c = col_pos;
            r = row_pos;
            if (c >= w) c = w - 1;
            if (r >= h) r = h - 1;
            lc = (c == w - 1);
            lr = (r == h - 1);
            inputs_seen++;
            if (r > 0) begin
                pending_px.push_back(shade(12'(c), 12'(r - 1), line_buf[c],
                    lc ? line_buf[c] : line_buf[c + 1], cur));
                n++;
            end
            if (lr) begin
                if (c > 0) begin
                    pending_px.push_back(shade(12'(c - 1), 12'(r), last_height, cur,
                        last_height));
                    n++;
                end
                if (lc) begin
                    pending_px.push_back(shade(12'(c), 12'(r), cur, cur, cur));
                    n++;
                end
            end
            if (n > 0) pending_px[$].run_end = 1;
            line_buf[c] = cur;
            last_height = cur;
            if (lc) begin
                col_pos = 0;
                row_pos = lr ? 12'd0 : 12'(r + 1);
            end else begin
                col_pos = 12'(c + 1);
                row_pos = 12'(r);
            end
        endfunction

        task check_px(input t_normal_px got);
            t_normal_px exp_px;
            results_seen++;
            if (pending_px.size() == 0) begin
                report($sformatf("unexpected result col %0d row %0d", got.col, got.row));
                return;
            end
            exp_px = pending_px.pop_front();
            if (got != exp_px)
                report($sformatf("got c%0d r%0d b%0h g%0h r%0h e%0b exp c%0d r%0d b%0h g%0h r%0h e%0b",
                    got.col, got.row, got.blue, got.green, got.red, got.run_end,
                    exp_px.col, exp_px.row, exp_px.blue, exp_px.green, exp_px.red,
                    exp_px.run_end));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_height_sample;
    logic        o_valid;
    logic        i_stall;
    logic [11:0] o_out_col;
    logic [11:0] o_out_row;
    logic [7:0]  o_blue_z;
    logic [7:0]  o_green_y;
    logic [7:0]  o_red_x;
    logic        o_run_end;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    normal_scoreboard sb;
    bit idle_on;
    int quiet_cycles;
    int settings_used;

    height_to_normal_map_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_height_sample(i_height_sample),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_col(o_out_col), .o_out_row(o_out_row), .o_blue_z(o_blue_z),
        .o_green_y(o_green_y), .o_red_x(o_red_x), .o_run_end(o_run_end),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_height_sample = 0;
        i_stall = 0;
        i_cfg_we = 0;
        i_cfg_idx = 0;
        i_cfg_data = 0;
        sb = new();
        idle_on = 1;
        quiet_cycles = 0;
        settings_used = 0;
    end

    always @(posedge i_clk) begin
        t_normal_px got;
        if (i_rst_n) begin
            quiet_cycles++;
            if (o_valid && !i_stall) begin
                got.col = o_out_col;
                got.row = o_out_row;
                got.blue = o_blue_z;
                got.green = o_green_y;
                got.red = o_red_x;
                got.run_end = o_run_end;
                sb.check_px(got);
                quiet_cycles = 0;
            end
            if (i_valid && !o_stall) begin
                sb.note_height(i_height_sample);
                quiet_cycles = 0;
            end
            if (i_cfg_we) sb.write_reg(i_cfg_idx, i_cfg_data);
            if (quiet_cycles >= WatchLimit) begin
                $display("watchdog: no progress, %0d results outstanding",
                    sb.pending_px.size());
                $display("height_to_normal_map_top_tb: errors");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= idle_on && ($urandom_range(99) < 31);
    end

    task send_height(input bit [7:0] h);
        while (idle_on && $urandom_range(99) < 31) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_height_sample <= h;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task drain_and_settle();
        i_valid <= 0;
        @(negedge i_clk);
        while (sb.pending_px.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task write_cfg(input bit [1:0] idx, input bit [15:0] data);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 0;
        @(negedge i_clk);
    endtask

    task set_geometry(input bit [15:0] w, input bit [15:0] h, input bit [15:0] s);
        drain_and_settle();
        write_cfg(hnm_pkg::CfgWidth, w);
        write_cfg(hnm_pkg::CfgHeight, h);
        write_cfg(hnm_pkg::CfgStrength, s);
        settings_used++;
    endtask

    initial begin
        int w;
        int h;
        int n;
        int sent;
        bit [15:0] s;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // small frame with alternating extremes
        set_geometry(3, 3, 256);
        for (int k = 0; k < 9; k++) send_height((k % 2) ? 8'hFF : 8'h00);
        set_geometry(1, 1, 16'h8000);
        send_height(8'hFF);
        send_height(8'h00);
        set_geometry(2, 2, 16'h7FFF);
        send_height(8'h00);
        send_height(8'hFF);
        send_height(8'hFF);
        send_height(8'h00);
        set_geometry(2, 1, 0);
        send_height(8'h12);
        send_height(8'hED);
        // out-of-list index leaves the frame where it is
        drain_and_settle();
        write_cfg(2'd3, 16'hFFFF);
        send_height(8'h40);
        send_height(8'hC0);

        // saturated, zero and maximum width and height
        set_geometry(16'hFFFF, 1, 16'h0180);
        for (int k = 0; k < 20; k++) send_height(8'($urandom_range(255)));
        set_geometry(0, 16'hFFFF, 16'hFF00);
        for (int k = 0; k < 20; k++) send_height(8'($urandom_range(255)));
        set_geometry(4096, 1, 256);
        for (int k = 0; k < 6; k++) send_height(8'($urandom_range(255)));
        set_geometry(1, 4096, 256);
        for (int k = 0; k < 6; k++) send_height(8'($urandom_range(255)));

        sent = 0;
        while (sent < RandItems) begin
            idle_on = !(sent > RandItems / 3 && sent < RandItems / 2);
            w = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
            h = $urandom_range(0, 5);
            case ($urandom_range(3))
                0: s = 16'($urandom_range(16'hFFFF));
                1: s = 16'($signed($urandom_range(0, 1024)) - 512);
                2: s = ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
                default: s = 256;
            endcase
            set_geometry(16'(w), 16'(h), s);
            n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h) * $urandom_range(1, 2);
            if ($urandom_range(4) == 0) n = $urandom_range(1, n);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(3) == 0) send_height(8'($urandom_range(255)));
                else send_height(8'($urandom_range(100, 140)));
            end
            sent += n;
        end
        idle_on = 1;

        drain_and_settle();
        $display("covered %0d heights, %0d normals over %0d register settings",
            sb.inputs_seen, sb.results_seen, settings_used);
        if (sb.errors == 0) begin
            $display("height_to_normal_map_top_tb: clean");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("height_to_normal_map_top_tb: errors");
        end
        $finish;
    end

endmodule

@@ height_to_normal_map_top.f @@
rtl/core/hnm_pkg.sv
rtl/core/hnm_queue.sv
rtl/core/hnm_front.sv
rtl/core/hnm_back.sv
rtl/core/height_to_normal_map_top.sv
verif/height_to_normal_map_top_tb.sv
